### rtl/ptfp_pkg.sv
// ----------------------------------------------------------------------------
// ptfp_pkg
// Shared constants and the CRC-8 helper for the telemetry frame parser.
// ----------------------------------------------------------------------------
package ptfp_pkg;

    localparam logic [7:0] HDR_BYTE      = 8'hFF;
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
    localparam logic [7:0] CRC_INIT      = 8'h00;

    // Reflected CRC-8 Maxim, one byte, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### rtl/ptfp_ifs.sv
// ----------------------------------------------------------------------------
// ptfp channel interfaces
// Valid/ready channels for received bytes and for parsed frame reports.
// ----------------------------------------------------------------------------
interface ptfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ptfp_report_if;
    logic        valid;
    logic        ready;
    logic [7:0]  voltage_volts;
    logic [7:0]  current_tenths_amp;
    logic [15:0] power_tenths_watt;
    logic        crc_ok;
    logic [7:0]  received_crc;

    modport source (output valid, output voltage_volts, output current_tenths_amp,
                    output power_tenths_watt, output crc_ok, output received_crc,
                    input ready);
    modport sink   (input valid, input voltage_volts, input current_tenths_amp,
                    input power_tenths_watt, input crc_ok, input received_crc,
                    output ready);
endinterface

### rtl/power_telemetry_frame_parser.sv
// ----------------------------------------------------------------------------
// power_telemetry_frame_parser
// Hunts for 0xFF headers in a byte stream and reports voltage, current,
// power and CRC check for each four-byte frame.
// ----------------------------------------------------------------------------
// Reporting: an accepted CRC byte first sits in the input register, then
//   moves to the report register, which drives the frame report.
// Throughput: one byte per cycle; the report register frees the byte side
//   unless a report is pending and the next frame end is ready to be written.
// Reset: rst_n clears the frame phase, CRC and held bytes; parser starts hunting.
module power_telemetry_frame_parser
    import ptfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ptfp_byte_if.sink            rx,
    ptfp_report_if.source        report
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_VOLT,
        PH_CURR,
        PH_CRC
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [7:0]  crc_reg,     crc_next;
    logic [7:0]  volt_reg,    volt_next;
    logic [7:0]  curr_reg,    curr_next;

    logic        byte_valid_reg, byte_valid_next;
    logic [7:0]  byte_reg,       byte_next;

    logic        out_valid_reg,  out_valid_next;
    logic [7:0]  out_volt_reg,   out_volt_next;
    logic [7:0]  out_curr_reg,   out_curr_next;
    logic [15:0] out_pwr_reg,    out_pwr_next;
    logic        out_ok_reg,     out_ok_next;
    logic [7:0]  out_crc_reg,    out_crc_next;

    logic        emits;
    logic        out_free;
    logic        advance;
    logic        rx_ready;

    assign emits    = (phase_reg == PH_CRC);
    assign out_free = !out_valid_reg || report.ready;
    // non-reporting bytes never wait on the report side
    assign advance  = byte_valid_reg && (!emits || out_free);
    assign rx_ready = !byte_valid_reg || advance;
    assign rx.ready = rx_ready;

    always_comb
    begin
        phase_next      = phase_reg;
        crc_next        = crc_reg;
        volt_next       = volt_reg;
        curr_next       = curr_reg;
        byte_valid_next = byte_valid_reg;
        byte_next       = byte_reg;
        out_valid_next  = out_valid_reg;
        out_volt_next   = out_volt_reg;
        out_curr_next   = out_curr_reg;
        out_pwr_next    = out_pwr_reg;
        out_ok_next     = out_ok_reg;
        out_crc_next    = out_crc_reg;

        if (out_valid_reg && report.ready)
            out_valid_next = 1'b0;

        if (advance)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (byte_reg == HDR_BYTE)
                    begin
                        crc_next   = crc8_byte(CRC_INIT, byte_reg);
                        phase_next = PH_VOLT;
                    end
                end
                PH_VOLT:
                begin
                    volt_next  = byte_reg;
                    crc_next   = crc8_byte(crc_reg, byte_reg);
                    phase_next = PH_CURR;
                end
                PH_CURR:
                begin
                    curr_next  = byte_reg;
                    crc_next   = crc8_byte(crc_reg, byte_reg);
                    phase_next = PH_CRC;
                end
                PH_CRC:
                begin
                    out_valid_next = 1'b1;
                    out_volt_next  = volt_reg;
                    out_curr_next  = curr_reg;
                    out_pwr_next   = 16'(volt_reg) * 16'(curr_reg);
                    out_ok_next    = (crc_reg == byte_reg);
                    out_crc_next   = byte_reg;
                    phase_next     = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        if (rx_ready)
        begin
            byte_valid_next = rx.valid;
            byte_next       = rx.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            crc_reg        <= CRC_INIT;
            volt_reg       <= '0;
            curr_reg       <= '0;
            byte_valid_reg <= 1'b0;
            byte_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_volt_reg   <= '0;
            out_curr_reg   <= '0;
            out_pwr_reg    <= '0;
            out_ok_reg     <= 1'b0;
            out_crc_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            crc_reg        <= crc_next;
            volt_reg       <= volt_next;
            curr_reg       <= curr_next;
            byte_valid_reg <= byte_valid_next;
            byte_reg       <= byte_next;
            out_valid_reg  <= out_valid_next;
            out_volt_reg   <= out_volt_next;
            out_curr_reg   <= out_curr_next;
            out_pwr_reg    <= out_pwr_next;
            out_ok_reg     <= out_ok_next;
            out_crc_reg    <= out_crc_next;
        end
    end

    assign report.valid              = out_valid_reg;
    assign report.voltage_volts      = out_volt_reg;
    assign report.current_tenths_amp = out_curr_reg;
    assign report.power_tenths_watt  = out_pwr_reg;
    assign report.crc_ok             = out_ok_reg;
    assign report.received_crc       = out_crc_reg;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: telemetry frame parser testbench
// Streams header-framed telemetry bytes into the parser with random gaps and
// backpressure. An in-bench frame decoder predicts each report, and reports
// are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top
    import ptfp_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_FRAMES = 340;

    typedef enum logic [1:0] {
        SEEK_HEADER,
        TAKE_VOLTAGE,
        TAKE_CURRENT,
        TAKE_CHECK
    } parse_phase_t;

    typedef struct {
        logic [7:0] value;
        bit         drain_first;
    } rx_item_t;

    typedef struct {
        logic [7:0]  volts;
        logic [7:0]  amps_tenths;
        logic [15:0] watts_tenths;
        logic        crc_match;
        logic [7:0]  crc_byte;
    } frame_report_t;

    logic clk;
    logic rst_n;

    ptfp_byte_if   rx_if();
    ptfp_report_if rep_if();

    power_telemetry_frame_parser u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .report (rep_if)
    );

    rx_item_t      pending_bytes[$];
    frame_report_t expected_reports[$];
    int            bytes_queued;
    int            bytes_accepted;
    int            error_count;
    int            cycle_count;

    // decoder state
    parse_phase_t  phase_q;
    logic [7:0]    crc_acc;
    logic [7:0]    volts_q;
    logic [7:0]    amps_q;

    // Maxim CRC-8, reflected, processed one bit at a time LSB first
    function automatic logic [7:0] maxim_crc_update(input logic [7:0] acc,
                                                    input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ data[i];
            r  = {1'b0, r[7:1]};
            if (fb)
                r = r ^ CRC_POLY_REFL;
        end
        return r;
    endfunction

    function automatic logic [7:0] frame_crc(input logic [7:0] v, input logic [7:0] c);
        return maxim_crc_update(maxim_crc_update(maxim_crc_update(CRC_INIT, HDR_BYTE), v), c);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // advance the frame decoder by one accepted byte
    function automatic void decode_byte(input logic [7:0] b);
        frame_report_t rep;
        case (phase_q)
            SEEK_HEADER:
            begin
                if (b == HDR_BYTE)
                begin
                    crc_acc = maxim_crc_update(CRC_INIT, b);
                    phase_q = TAKE_VOLTAGE;
                end
            end
            TAKE_VOLTAGE:
            begin
                volts_q = b;
                crc_acc = maxim_crc_update(crc_acc, b);
                phase_q = TAKE_CURRENT;
            end
            TAKE_CURRENT:
            begin
                amps_q  = b;
                crc_acc = maxim_crc_update(crc_acc, b);
                phase_q = TAKE_CHECK;
            end
            default:
            begin
                rep.volts        = volts_q;
                rep.amps_tenths  = amps_q;
                rep.watts_tenths = 16'(volts_q) * 16'(amps_q);
                rep.crc_match    = (crc_acc == b);
                rep.crc_byte     = b;
                expected_reports.push_back(rep);
                phase_q = SEEK_HEADER;
            end
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b, input bit drain);
        rx_item_t it;
        it.value       = b;
        it.drain_first = drain;
        pending_bytes.push_back(it);
        bytes_queued++;
    endtask

    // bad_crc selects a good CRC (0) or a corrupted CRC (1)
    task automatic add_frame(input logic [7:0] v, input logic [7:0] c, input bit bad_crc,
                             input bit drain);
        logic [7:0] k;
        k = frame_crc(v, c);
        if (bad_crc)
            k = k ^ 8'($urandom_range(1, 255));
        add_byte(HDR_BYTE, drain);
        add_byte(v, 1'b0);
        add_byte(c, 1'b0);
        add_byte(k, 1'b0);
    endtask

    function automatic logic [7:0] pick_field();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d of %0d bytes accepted, %0d reports outstanding",
                     $time, bytes_accepted, bytes_queued, expected_reports.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // byte driver; decodes each accepted transaction before choosing the next one
    int tx_idle_left;
    int tx_burst_left;

    always @(posedge clk or negedge rst_n)
    begin
        rx_item_t it;
        if (!rst_n)
        begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= 8'h00;
            tx_idle_left  = 0;
            tx_burst_left = 0;
        end
        else
        begin
            if (rx_if.valid && rx_if.ready)
            begin
                decode_byte(rx_if.rx_byte);
                bytes_accepted++;
            end
            if (!rx_if.valid || rx_if.ready)
            begin
                if (tx_idle_left > 0)
                begin
                    tx_idle_left--;
                    rx_if.valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0 &&
                         !(pending_bytes[0].drain_first && expected_reports.size() != 0))
                begin
                    it = pending_bytes.pop_front();
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= it.value;
                    if (tx_burst_left > 0)
                    begin
                        tx_burst_left--;
                        tx_idle_left = 0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 99) == 0)
                            tx_burst_left = $urandom_range(30, 80);
                        tx_idle_left = pick_gap();
                    end
                end
                else
                    rx_if.valid <= 1'b0;
            end
        end
    end

    // report monitor with random backpressure
    int rx_stall_left;
    int rx_quiet_left;

    always @(posedge clk or negedge rst_n)
    begin
        frame_report_t want;
        if (!rst_n)
        begin
            rep_if.ready  <= 1'b0;
            rx_stall_left = 0;
            rx_quiet_left = 0;
        end
        else
        begin
            if (rep_if.valid && rep_if.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected report V=%0d I=%0d P=%0d ok=%0b crc=%02h", $time,
                             rep_if.voltage_volts, rep_if.current_tenths_amp,
                             rep_if.power_tenths_watt, rep_if.crc_ok, rep_if.received_crc);
                    error_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (rep_if.voltage_volts !== want.volts)
                    begin
                        $display("%0t: voltage_volts expected %0d actual %0d", $time,
                                 want.volts, rep_if.voltage_volts);
                        error_count++;
                    end
                    if (rep_if.current_tenths_amp !== want.amps_tenths)
                    begin
                        $display("%0t: current_tenths_amp expected %0d actual %0d", $time,
                                 want.amps_tenths, rep_if.current_tenths_amp);
                        error_count++;
                    end
                    if (rep_if.power_tenths_watt !== want.watts_tenths)
                    begin
                        $display("%0t: power_tenths_watt expected %0d actual %0d", $time,
                                 want.watts_tenths, rep_if.power_tenths_watt);
                        error_count++;
                    end
                    if (rep_if.crc_ok !== want.crc_match)
                    begin
                        $display("%0t: crc_ok expected %0b actual %0b", $time,
                                 want.crc_match, rep_if.crc_ok);
                        error_count++;
                    end
                    if (rep_if.received_crc !== want.crc_byte)
                    begin
                        $display("%0t: received_crc expected %02h actual %02h", $time,
                                 want.crc_byte, rep_if.received_crc);
                        error_count++;
                    end
                end
            end

            if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                rep_if.ready <= 1'b0;
            end
            else if (rx_quiet_left > 0)
            begin
                rx_quiet_left--;
                rep_if.ready <= 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    rx_quiet_left = $urandom_range(50, 200);
                if ($urandom_range(0, 99) < 30)
                begin
                    rx_stall_left = pick_gap();
                    rep_if.ready <= (rx_stall_left == 0);
                end
                else
                    rep_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int r;
        rst_n          = 1'b0;
        bytes_queued   = 0;
        bytes_accepted = 0;
        error_count    = 0;
        cycle_count    = 0;
        phase_q        = SEEK_HEADER;
        crc_acc        = CRC_INIT;
        volts_q        = 8'h00;
        amps_q         = 8'h00;

        // directed: noise while hunting, field extremes, 0xFF as data, bad CRC,
        // back-to-back frames
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'hFE, 1'b0);
        add_frame(8'h00, 8'h00, 1'b0, 1'b0);
        add_frame(8'hFF, 8'hFF, 1'b0, 1'b0);
        add_frame(8'hFF, 8'h01, 1'b1, 1'b0);
        add_frame(8'h01, 8'hFE, 1'b0, 1'b0);
        add_frame(8'h0A, 8'h96, 1'b1, 1'b0);

        // random: mostly well-formed frames, some noise and truncated frames
        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                add_frame(pick_field(), pick_field(), 1'b0,
                          (n == 40) || (n == 160) || ($urandom_range(0, 99) == 0));
            else if (r < 82)
                add_frame(pick_field(), pick_field(), 1'b1, 1'b0);
            else if (r < 92)
            begin
                // line noise between frames
                repeat ($urandom_range(1, 4))
                    add_byte(8'($urandom_range(0, 254)), 1'b0);
            end
            else
            begin
                // header then a short run of bytes; whatever follows completes it
                add_byte(HDR_BYTE, 1'b0);
                repeat ($urandom_range(1, 2))
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (bytes_accepted == bytes_queued);
        wait (expected_reports.size() == 0);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
rtl/ptfp_pkg.sv
rtl/ptfp_ifs.sv
rtl/power_telemetry_frame_parser.sv
bench/tb_top.sv
